// ----- sv/tta_pkg.sv -----
// Package for the toroidal three-state automaton core.
// Holds the opcode, cell and result codes, the controller state type, the
// controller/datapath command and status structs and the cell update rule.
`default_nettype none

package tta_pkg;

  // Host opcodes; code three is ignored.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Cell contents
  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_A     = 2'd1,
    CELL_B     = 2'd2,
    CELL_INERT = 2'd3
  } cell_t;

  // Result kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_CAP_DN,
    ST_CELLS,
    ST_DRAIN,
    ST_ROW_WR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // write one cell from the host word
    logic read;       // read one cell for the host
    logic gen_init;   // start a generation at row zero
    logic rd_up;      // fetch the A-map row above
    logic rd_mid;     // fetch the A-map row itself
    logic rd_dn;      // fetch the A-map row below
    logic cap_dn;     // capture the row below, rewind column
    logic cell_issue; // read the next cell of the row
    logic row_write;  // store the new A-map row
    logic row_next;   // advance to the next row
    logic copy_init;  // point at the first row outside the region
    logic copy_rd;    // fetch an A-map row outside the region
    logic copy_wr;    // store it into the other bank
    logic copy_next;  // advance the copy row
    logic finish;     // swap A-map banks and report the generation
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic col_last;
    logic row_last;
    logic copy_none;
    logic copy_last;
  } dp_status_t;

  // One-generation update of a single cell
  function automatic cell_t next_cell(input cell_t v, input logic near_a);
    cell_t n;
    n = v;
    case (v)
      CELL_A:     n = CELL_B;
      CELL_B:     n = near_a ? CELL_EMPTY : CELL_A;
      CELL_EMPTY: n = near_a ? CELL_A : CELL_EMPTY;
      default:    n = v;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/toroidal_three_state_automaton_core.sv -----
// Load and read: accepted while idle, result strobed on done the next cycle;
//   a new word may be started in the cycle after acceptance.
// Step: busy while the clamped region (w, h) is swept: per row, the rows above, itself
//   and below are fetched, one cell access per cell, then drain and write; after that
//   each row outside the region is copied; done strobes as busy falls.
// Reset: synchronous; registers return to 64 by 64, memories are not cleared.
`default_nettype none

module toroidal_three_state_automaton_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [5:0] row,
  input  wire logic [5:0] col,
  input  wire logic [1:0] cell_in,
  output logic            done,
  output logic [1:0]      kind,
  output logic [1:0]      cell_out,
  input  wire logic       cfg_we,
  input  wire logic       cfg_addr,
  input  wire logic [6:0] cfg_data
);
  import tta_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  tta_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Storage and cell update
  tta_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .row      (row),
    .col      (col),
    .cell_in  (cell_in),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .done     (done),
    .kind     (kind),
    .cell_out (cell_out)
  );

endmodule

`default_nettype wire

// ----- sv/tta_ctrl.sv -----
// Controller of the toroidal three-state automaton core.
// Sequences loads, reads and generation sweeps; depends on tta_pkg.
`default_nettype none

module tta_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         op,
  input  wire tta_pkg::dp_status_t status,
  output tta_pkg::ctrl_cmd_t      cmd,
  output logic                    busy
);
  import tta_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (op_t'(op))
            OP_LOAD: cmd.load = 1'b1;
            OP_READ: cmd.read = 1'b1;
            OP_STEP: begin
              cmd.gen_init = 1'b1;
              state_next   = ST_RD_UP;
            end
            default: ;
          endcase
        end
      end
      ST_RD_UP: begin
        cmd.rd_up  = 1'b1;
        state_next = ST_RD_MID;
      end
      ST_RD_MID: begin
        cmd.rd_mid = 1'b1;
        state_next = ST_RD_DN;
      end
      ST_RD_DN: begin
        cmd.rd_dn  = 1'b1;
        state_next = ST_CAP_DN;
      end
      ST_CAP_DN: begin
        cmd.cap_dn = 1'b1;
        state_next = ST_CELLS;
      end
      ST_CELLS: begin
        cmd.cell_issue = 1'b1;
        if (status.col_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_ROW_WR;
      end
      ST_ROW_WR: begin
        cmd.row_write = 1'b1;
        if (!status.row_last) begin
          cmd.row_next = 1'b1;
          state_next   = ST_RD_UP;
        end else if (status.copy_none) begin
          state_next = ST_FINISH;
        end else begin
          cmd.copy_init = 1'b1;
          state_next    = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_next  = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (status.copy_last) begin
          state_next = ST_FINISH;
        end else begin
          cmd.copy_next = 1'b1;
          state_next    = ST_COPY_RD;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/tta_datapath.sv -----
// Datapath of the toroidal three-state automaton core: cell memory,
// double-banked A-map row memory, row window registers, counters, results.
// Depends on tta_pkg; driven by tta_ctrl.
`default_nettype none

module tta_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tta_pkg::ctrl_cmd_t cmd,
  output tta_pkg::dp_status_t     status,
  input  wire logic [5:0]         row,
  input  wire logic [5:0]         col,
  input  wire logic [1:0]         cell_in,
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic [6:0]         cfg_data,
  output logic                    done,
  output logic [1:0]              kind,
  output logic [1:0]              cell_out
);
  import tta_pkg::*;

  localparam int RA = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CA = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WE = $clog2(MAX_WIDTH + 1);
  localparam int HE = $clog2(MAX_HEIGHT + 1);

  // Memories: cells, and one A bit per cell in two banks of rows
  logic [1:0]           gmem [MAX_HEIGHT][MAX_WIDTH];
  logic [MAX_WIDTH-1:0] amem [2][MAX_HEIGHT];

  logic [6:0]           grid_width, grid_height;
  logic [WE-1:0]        w_eff;
  logic [HE-1:0]        h_eff;
  logic                 bank;
  logic [RA-1:0]        r_cnt;
  logic [CA-1:0]        c_cnt;
  logic [RA-1:0]        up_row, dn_row, a_raddr;
  logic                 a_ren;
  logic [MAX_WIDTH-1:0] aq, up_q, mid_q, dn_q, new_row;
  logic                 p_valid;
  logic [CA-1:0]        p_col, cm, cp;
  logic [1:0]           grid_q;
  logic [RA-1:0]        h_row;
  logic [CA-1:0]        h_col;
  logic                 in_grid, in_grid_q;
  logic                 near_a;
  cell_t                cell_new;
  logic [RA-1:0]        g_rrow;
  logic [CA-1:0]        g_rcol;
  logic                 g_ren;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the region to one..maximum
  always_comb begin
    if (grid_width == 7'd0) begin
      w_eff = WE'(1);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      w_eff = WE'(MAX_WIDTH);
    end else begin
      w_eff = WE'(grid_width);
    end
    if (grid_height == 7'd0) begin
      h_eff = HE'(1);
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HE'(MAX_HEIGHT);
    end else begin
      h_eff = HE'(grid_height);
    end
  end

  // Host cell address
  assign h_row   = RA'(row);
  assign h_col   = CA'(col);
  assign in_grid = (32'(row) < 32'(MAX_HEIGHT)) && (32'(col) < 32'(MAX_WIDTH));

  // Wrapped neighbor rows and columns
  assign up_row = (r_cnt == '0) ? RA'(h_eff - HE'(1)) : r_cnt - RA'(1);
  assign dn_row = (HE'(r_cnt) == h_eff - HE'(1)) ? '0 : r_cnt + RA'(1);
  assign cm     = (p_col == '0) ? CA'(w_eff - WE'(1)) : p_col - CA'(1);
  assign cp     = (WE'(p_col) == w_eff - WE'(1)) ? '0 : p_col + CA'(1);

  // Status
  assign status.col_last  = (WE'(c_cnt) == w_eff - WE'(1));
  assign status.row_last  = (HE'(r_cnt) == h_eff - HE'(1));
  assign status.copy_none = (h_eff == HE'(MAX_HEIGHT));
  assign status.copy_last = (32'(r_cnt) == 32'(MAX_HEIGHT - 1));

  // Row and column counters, bank pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (cmd.finish) begin
      bank <= ~bank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_init) begin
      r_cnt <= '0;
    end else if (cmd.copy_init) begin
      r_cnt <= RA'(h_eff);
    end else if (cmd.row_next || cmd.copy_next) begin
      r_cnt <= r_cnt + RA'(1);
    end
    if (cmd.cap_dn) begin
      c_cnt <= '0;
    end else if (cmd.cell_issue) begin
      c_cnt <= c_cnt + CA'(1);
    end
  end

  // A-map read: one row per cycle from the current bank
  assign a_ren   = cmd.rd_up | cmd.rd_mid | cmd.rd_dn | cmd.copy_rd;
  assign a_raddr = cmd.rd_up ? up_row : (cmd.rd_dn ? dn_row : r_cnt);

  always_ff @(posedge clk) begin
    if (a_ren) begin
      aq <= amem[bank][a_raddr];
    end
  end

  // A-map write: single bit on load, whole row into the other bank otherwise
  always_ff @(posedge clk) begin
    if (cmd.load && in_grid) begin
      amem[bank][h_row][h_col] <= (cell_t'(cell_in) == CELL_A);
    end else if (cmd.row_write) begin
      amem[~bank][r_cnt] <= new_row;
    end else if (cmd.copy_wr) begin
      amem[~bank][r_cnt] <= aq;
    end
  end

  // Row window: above, itself, below; new row starts as the old one
  always_ff @(posedge clk) begin
    if (cmd.rd_mid) begin
      up_q <= aq;
    end
    if (cmd.rd_dn) begin
      mid_q   <= aq;
      new_row <= aq;
    end else if (p_valid) begin
      new_row[p_col] <= (cell_new == CELL_A);
    end
    if (cmd.cap_dn) begin
      dn_q <= aq;
    end
  end

  // Cell pipeline: read a cell, update and write it back next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.cell_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_issue) begin
      p_col <= c_cnt;
    end
  end

  assign near_a = up_q[cm] | up_q[p_col] | up_q[cp] | mid_q[cm] | mid_q[cp] |
                  dn_q[cm] | dn_q[p_col] | dn_q[cp];
  assign cell_new = next_cell(cell_t'(grid_q), near_a);

  // Cell memory read port
  assign g_ren  = cmd.read | cmd.cell_issue;
  assign g_rrow = cmd.read ? h_row : r_cnt;
  assign g_rcol = cmd.read ? h_col : c_cnt;

  always_ff @(posedge clk) begin
    if (g_ren) begin
      grid_q <= gmem[g_rrow][g_rcol];
    end
  end

  // Cell memory write port
  always_ff @(posedge clk) begin
    if (cmd.load && in_grid) begin
      gmem[h_row][h_col] <= cell_in;
    end else if (p_valid) begin
      gmem[r_cnt][p_col] <= cell_new;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.load | cmd.read | cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= KIND_LOAD;
    end else if (cmd.read) begin
      kind      <= KIND_READ;
      in_grid_q <= in_grid;
    end else if (cmd.finish) begin
      kind <= KIND_STEP;
    end
  end

  assign cell_out = (done && kind == KIND_READ && in_grid_q) ? grid_q : 2'd0;

endmodule

`default_nettype wire

// ----- verif/toroidal_three_state_automaton_core_tb.sv -----
// Testbench for toroidal_three_state_automaton_core: loads, reads and generation
// steps checked word by word against a shadow grid kept in the bench.
// Depends on tta_pkg and the core RTL only.
`timescale 1ns / 100ps

module toroidal_three_state_automaton_core_tb;
  import tta_pkg::*;

  localparam int          GRID_MAX     = 64;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          SETTLE_TICKS = 8;
  localparam logic [1:0]  OP_IGNORED   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] cell_out;
  } reply_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] op;
  logic [5:0] row;
  logic [5:0] col;
  logic [1:0] cell_in;
  logic       done;
  logic [1:0] kind;
  logic [1:0] cell_out;
  logic       cfg_we;
  logic       cfg_addr;
  logic [6:0] cfg_data;

  // Shadow of the core: current grid, grid at start of a generation, extent
  cell_t      grid_now  [GRID_MAX][GRID_MAX];
  cell_t      grid_prev [GRID_MAX][GRID_MAX];
  bit         cell_loaded [GRID_MAX][GRID_MAX];
  logic [11:0] loaded_spots[$];
  logic [6:0] width_reg;
  logic [6:0] height_reg;

  reply_t     replies_due[$];
  reply_t     oldest_reply;
  int         mismatch_count;
  int         burst_left;
  int         cycle_count;

  toroidal_three_state_automaton_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .row      (row),
    .col      (col),
    .cell_in  (cell_in),
    .done     (done),
    .kind     (kind),
    .cell_out (cell_out),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Zero acts as one, anything past the storage saturates
  function automatic int clamp_extent(input logic [6:0] value);
    if (value == 7'd0) return 1;
    if (value > GRID_MAX) return GRID_MAX;
    return int'(value);
  endfunction

  function automatic bit a_in_neighborhood(input int r, input int c, input int ext_w,
                                           input int ext_h);
    int nr;
    int nc;
    bit found;
    found = 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          nr = (r + ext_h + dr) % ext_h;
          nc = (c + ext_w + dc) % ext_w;
          if (grid_prev[nr][nc] == CELL_A) found = 1'b1;
        end
      end
    end
    return found;
  endfunction

  // Advance the shadow grid by one generation over the region in use
  function automatic void advance_generation();
    int    ext_w;
    int    ext_h;
    bit    near_a;
    cell_t v;
    ext_w = clamp_extent(width_reg);
    ext_h = clamp_extent(height_reg);
    grid_prev = grid_now;
    for (int r = 0; r < ext_h; r++) begin
      for (int c = 0; c < ext_w; c++) begin
        v = grid_prev[r][c];
        near_a = a_in_neighborhood(r, c, ext_w, ext_h);
        case (v)
          CELL_A: grid_now[r][c] = CELL_B;
          CELL_B: grid_now[r][c] = near_a ? CELL_EMPTY : CELL_A;
          CELL_EMPTY: begin
            if (near_a) grid_now[r][c] = CELL_A;
          end
          default: ;
        endcase
      end
    end
  endfunction

  // Apply one accepted word to the shadow grid and queue the reply it causes
  function automatic void shadow_apply(input logic [1:0] w_op, input logic [5:0] w_row,
                                       input logic [5:0] w_col, input logic [1:0] w_cell);
    reply_t reply;
    reply.cell_out = 2'd0;
    case (w_op)
      OP_LOAD: begin
        grid_now[w_row][w_col] = cell_t'(w_cell);
        if (!cell_loaded[w_row][w_col]) begin
          cell_loaded[w_row][w_col] = 1'b1;
          loaded_spots.push_back({w_row, w_col});
        end
        reply.kind = KIND_LOAD;
        replies_due.push_back(reply);
      end
      OP_STEP: begin
        advance_generation();
        reply.kind = KIND_STEP;
        replies_due.push_back(reply);
      end
      OP_READ: begin
        reply.kind     = KIND_READ;
        reply.cell_out = grid_now[w_row][w_col];
        replies_due.push_back(reply);
      end
      default: ;
    endcase
  endfunction

  function automatic cell_t random_cell();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return CELL_A;
    if (roll < 6) return CELL_B;
    if (roll < 9) return CELL_EMPTY;
    return CELL_INERT;
  endfunction

  // Burst the sender: random burst lengths, random gaps, some long runs
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one word and hold it until the core takes it
  task automatic send_word(input logic [1:0] w_op, input logic [5:0] w_row,
                           input logic [5:0] w_col, input logic [1:0] w_cell);
    pace_sender();
    start   <= 1'b1;
    op      <= w_op;
    row     <= w_row;
    col     <= w_col;
    cell_in <= w_cell;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow_apply(w_op, w_row, w_col, w_cell);
  endtask

  // Hold the sender until every reply is in, then let the core settle
  task automatic drain_replies();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_extent(input logic [6:0] w, input logic [6:0] h);
    drain_replies();
    cfg_we   <= 1'b1;
    cfg_addr <= REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_addr <= REG_GRID_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  task automatic test_corner_cells();
    send_word(OP_LOAD, 6'd0,  6'd0,  CELL_A);
    send_word(OP_LOAD, 6'd0,  6'd63, CELL_B);
    send_word(OP_LOAD, 6'd63, 6'd0,  CELL_INERT);
    send_word(OP_LOAD, 6'd63, 6'd63, CELL_EMPTY);
    send_word(OP_READ, 6'd0,  6'd0,  2'd3);
    send_word(OP_READ, 6'd0,  6'd63, 2'd0);
    send_word(OP_READ, 6'd63, 6'd0,  2'd0);
    send_word(OP_READ, 6'd63, 6'd63, 2'd3);
  endtask

  // Opcode three must leave the grid alone and return nothing
  task automatic test_ignored_opcode();
    send_word(OP_IGNORED, 6'd0, 6'd0, CELL_INERT);
    send_word(OP_READ,    6'd0, 6'd0, 2'd0);
  endtask

  // 1x1 torus: the cell is its own neighbor eight times over
  task automatic test_single_cell_torus();
    set_extent(7'd0, 7'd0);
    send_word(OP_STEP, 6'd63, 6'd63, 2'd3);
    send_word(OP_READ, 6'd0,  6'd0,  2'd0);
    send_word(OP_STEP, 6'd0,  6'd0,  2'd0);
    send_word(OP_READ, 6'd0,  6'd0,  2'd0);
  endtask

  // 2x2 torus with one of each cell kind
  task automatic test_two_by_two_torus();
    set_extent(7'd2, 7'd2);
    send_word(OP_LOAD, 6'd0, 6'd1, CELL_B);
    send_word(OP_LOAD, 6'd1, 6'd0, CELL_EMPTY);
    send_word(OP_LOAD, 6'd1, 6'd1, CELL_INERT);
    send_word(OP_STEP, 6'd0, 6'd0, 2'd0);
    send_word(OP_READ, 6'd0, 6'd0, 2'd0);
    send_word(OP_READ, 6'd0, 6'd1, 2'd0);
    send_word(OP_READ, 6'd1, 6'd0, 2'd0);
    send_word(OP_READ, 6'd1, 6'd1, 2'd0);
  endtask

  // Fill the region, then mix steps, reads, loads, stray opcodes and pauses
  task automatic run_phase(input logic [6:0] w, input logic [6:0] h, input int word_count);
    int          ext_w;
    int          ext_h;
    int          pick;
    logic [11:0] spot;
    logic [5:0]  r;
    logic [5:0]  c;
    set_extent(w, h);
    ext_w = clamp_extent(w);
    ext_h = clamp_extent(h);
    for (int rr = 0; rr < ext_h; rr++) begin
      for (int cc = 0; cc < ext_w; cc++) begin
        if (!cell_loaded[rr][cc]) send_word(OP_LOAD, rr[5:0], cc[5:0], random_cell());
      end
    end
    repeat (word_count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_word(OP_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)));
      end else if (pick < 68) begin
        spot = loaded_spots[$urandom_range(0, loaded_spots.size() - 1)];
        send_word(OP_READ, spot[11:6], spot[5:0], 2'($urandom_range(0, 3)));
      end else if (pick < 90) begin
        if ($urandom_range(0, 9) < 7) begin
          r = 6'($urandom_range(0, ext_h - 1));
          c = 6'($urandom_range(0, ext_w - 1));
        end else begin
          r = 6'($urandom_range(0, 63));
          c = 6'($urandom_range(0, 63));
        end
        send_word(OP_LOAD, r, c, random_cell());
      end else if (pick < 93) begin
        drain_replies();
      end else begin
        send_word(OP_IGNORED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic test_random_phases();
    run_phase(7'd4,   7'd3,   16);
    run_phase(7'd127, 7'd1,   14);
    run_phase(7'd6,   7'd5,   18);
  endtask

  // Check each strobed reply against the oldest one due
  always @(posedge clk) begin
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        $error("unexpected word: kind %0d cell_out %0d", kind, cell_out);
        mismatch_count++;
      end else begin
        oldest_reply = replies_due.pop_front();
        if (kind !== oldest_reply.kind) begin
          $error("kind: expected %0d, got %0d", oldest_reply.kind, kind);
          mismatch_count++;
        end
        if (cell_out !== oldest_reply.cell_out) begin
          $error("cell_out: expected %0d, got %0d", oldest_reply.cell_out, cell_out);
          mismatch_count++;
        end
      end
    end
  end

  // Bail out if the core hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL toroidal_three_state_automaton_core");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    op         <= OP_LOAD;
    row        <= 6'd0;
    col        <= 6'd0;
    cell_in    <= 2'd0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_GRID_WIDTH;
    cfg_data   <= 7'd0;
    width_reg      = 7'd64;
    height_reg     = 7'd64;
    mismatch_count = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_corner_cells();
    test_ignored_opcode();
    test_single_cell_torus();
    test_two_by_two_torus();
    test_random_phases();

    drain_replies();
    if (mismatch_count == 0) begin
      $display("PASS toroidal_three_state_automaton_core");
    end else begin
      $display("FAIL toroidal_three_state_automaton_core");
    end
    $finish;
  end

endmodule
